// ===== rtl/euler_angles_to_quaternion_assert.svh =====
// Assertion macros for the Euler-to-quaternion block.
`ifndef EULER_ANGLES_TO_QUATERNION_ASSERT_SVH
`define EULER_ANGLES_TO_QUATERNION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EUQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("euq check failed");

// The consequent must hold in the cycle after the antecedent.
`define EUQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("euq check failed");

`endif

// ===== rtl/euq_pkg.sv =====
// Package with constants and the arctangent table for the Euler-to-quaternion block.
package euq_pkg;

  localparam int ANGLE_BITS_DEF   = 16;
  localparam int OUT_BITS_DEF     = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // CORDIC datapath width: Q2.30 values and phase with pi = 2^32 both fit.
  localparam int CW = 34;

  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd1073741824, 32'd633866812, 32'd334917814, 32'd170009512,
    32'd85334662,   32'd42708930,  32'd21359676,  32'd10680490,
    32'd5340326,    32'd2670174,   32'd1335088,   32'd667544,
    32'd333772,     32'd166886,    32'd83444,     32'd41722,
    32'd20860,      32'd10430,     32'd5216,      32'd2608,
    32'd1304,       32'd652,       32'd326,       32'd162,
    32'd82,         32'd40,        32'd20,        32'd10,
    32'd6,          32'd2,         32'd2,         32'd0
  };

  function automatic logic signed [CW-1:0] atan_step(input logic [4:0] k);
    atan_step = $signed({2'b00, ATAN_TAB[k]});
  endfunction

endpackage

// ===== rtl/euq_if.sv =====
// Valid/ready channel interfaces for angle input and quaternion output.
interface euq_in_if #(parameter int ANGLE_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] angle_x;
  logic signed [ANGLE_BITS-1:0] angle_y;
  logic signed [ANGLE_BITS-1:0] angle_z;
  modport source (output valid, angle_x, angle_y, angle_z, input ready);
  modport sink   (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface euq_out_if #(parameter int OUT_BITS = 16);
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] quat_w;
  logic signed [OUT_BITS-1:0] quat_x;
  logic signed [OUT_BITS-1:0] quat_y;
  logic signed [OUT_BITS-1:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ===== rtl/euler_angles_to_quaternion.sv =====
// Top level: Euler angles in, unit quaternion in signed fixed point out.
// Usage:
//   The input channel carries one beat per angle triple (x, y, z), each a
//   signed binary angle whose full range spans minus pi to pi. The output
//   channel carries one beat per triple holding w, x, y and z in signed
//   Q1.(OUT_BITS-1), saturated so that +1.0 reads as the largest code.
//   The pipeline runs through the CORDIC iterations (three angles in parallel
//   lanes), then each of the two chained multiplications as registered partial
//   products followed by their registered sum, and last a register after the
//   final add, rounding and saturation.
//   Throughput is one beat per cycle unless the receiver stalls; every
//   pipeline stage is a register stage with a valid bit moving with the data.
//   When the receiver stalls with a result waiting, the whole pipeline holds,
//   bubbles included, and the input stops taking beats; while the last stage
//   is empty everything moves, so an empty output slot never blocks the input.
//   Reset clears all valid bits; no beat emerges until one has been taken.
//   Items are independent, so nothing is carried from one beat to the next.
module euler_angles_to_quaternion import euq_pkg::*; #(
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int OUT_BITS     = OUT_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  euq_in_if.sink    in_i,
  euq_out_if.source out_o
);

  localparam int LAT = CORDIC_STEPS + 5;
  localparam int PW  = 2*CW;
  localparam int SW  = CW + 4;
  localparam int SHR = (OUT_BITS < 31) ? 31 - OUT_BITS : 0;
  localparam int SHL = (OUT_BITS > 31) ? 1 : 0;
  localparam int HALF_POS = (SHR > 0) ? SHR - 1 : 0;
  localparam logic signed [SW-1:0] HALF = (SHR > 0) ? (SW'(1) <<< HALF_POS) : '0;
  localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (OUT_BITS-1)) - 1);
  localparam logic signed [SW-1:0] LO = -HI - SW'(1);

  logic           en;
  logic [LAT-1:0] vld_q;

  // Stall everything only when a finished result is held by the receiver.
  assign en          = !vld_q[LAT-1] || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  // Index 0 = x, 1 = y, 2 = z.
  logic signed [CW-1:0] cs [3];
  logic signed [CW-1:0] sn [3];

  euq_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic_x (
    .clk_i, .en_i(en), .angle_i(in_i.angle_x), .cos_o(cs[0]), .sin_o(sn[0]));
  euq_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic_y (
    .clk_i, .en_i(en), .angle_i(in_i.angle_y), .cos_o(cs[1]), .sin_o(sn[1]));
  euq_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic_z (
    .clk_i, .en_i(en), .angle_i(in_i.angle_z), .cos_o(cs[2]), .sin_o(sn[2]));

  // First products: cz*cx, sz*sx, cz*sx, sz*cx. Each 34x34 product is split
  // on the second operand into a signed high part and an unsigned low part.
  logic signed [CW-1:0]     pa [4];
  logic signed [CW-1:0]     pb [4];
  logic signed [CW+17:0]    p1lo_q [4];
  logic signed [CW+16:0]    p1hi_q [4];
  logic signed [CW-1:0]     ab_q [4];
  logic signed [CW-1:0]     cy1_q, sy1_q, cy2_q, sy2_q;

  assign pa[0] = cs[2]; assign pb[0] = cs[0];
  assign pa[1] = sn[2]; assign pb[1] = sn[0];
  assign pa[2] = cs[2]; assign pb[2] = sn[0];
  assign pa[3] = sn[2]; assign pb[3] = cs[0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        p1lo_q[k] <= pa[k] * $signed({1'b0, pb[k][16:0]});
        p1hi_q[k] <= pa[k] * $signed(pb[k][CW-1:17]);
      end
      cy1_q <= cs[1];
      sy1_q <= sn[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        ab_q[k] <= CW'(((PW'(p1hi_q[k]) <<< 17) + PW'(p1lo_q[k])) >>> 30);
      end
      cy2_q <= cy1_q;
      sy2_q <= sy1_q;
    end
  end

  // Second products, in the order used by the sums below.
  logic signed [CW-1:0]  qa [8];
  logic signed [CW-1:0]  qc [8];
  logic signed [CW+17:0] p2lo_q [8];
  logic signed [CW+16:0] p2hi_q [8];
  logic signed [CW-1:0]  prod_q [8];

  assign qa[0] = ab_q[0]; assign qc[0] = cy2_q;
  assign qa[1] = ab_q[1]; assign qc[1] = sy2_q;
  assign qa[2] = ab_q[2]; assign qc[2] = cy2_q;
  assign qa[3] = ab_q[3]; assign qc[3] = sy2_q;
  assign qa[4] = ab_q[0]; assign qc[4] = sy2_q;
  assign qa[5] = ab_q[1]; assign qc[5] = cy2_q;
  assign qa[6] = ab_q[3]; assign qc[6] = cy2_q;
  assign qa[7] = ab_q[2]; assign qc[7] = sy2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 8; k++) begin
        p2lo_q[k] <= qa[k] * $signed({1'b0, qc[k][16:0]});
        p2hi_q[k] <= qa[k] * $signed(qc[k][CW-1:17]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 8; k++) begin
        prod_q[k] <= CW'(((PW'(p2hi_q[k]) <<< 17) + PW'(p2lo_q[k])) >>> 30);
      end
    end
  end

  // Final sums, rounding to the output width and saturation.
  logic signed [SW-1:0]       sum [4];
  logic signed [SW-1:0]       scl [4];
  logic signed [OUT_BITS-1:0] res_d [4];
  logic signed [OUT_BITS-1:0] res_q [4];

  always_comb begin
    sum[0] = SW'(prod_q[0]) + SW'(prod_q[1]);
    sum[1] = SW'(prod_q[2]) - SW'(prod_q[3]);
    sum[2] = SW'(prod_q[4]) + SW'(prod_q[5]);
    sum[3] = SW'(prod_q[6]) - SW'(prod_q[7]);
    for (int k = 0; k < 4; k++) begin
      scl[k] = ((sum[k] + HALF) >>> SHR) <<< SHL;
      if (scl[k] > HI) begin
        res_d[k] = OUT_BITS'(HI);
      end else if (scl[k] < LO) begin
        res_d[k] = OUT_BITS'(LO);
      end else begin
        res_d[k] = OUT_BITS'(scl[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_o.quat_w = res_q[0];
  assign out_o.quat_x = res_q[1];
  assign out_o.quat_y = res_q[2];
  assign out_o.quat_z = res_q[3];

endmodule

// ===== rtl/euq_cordic.sv =====
// Pipelined rotation-mode CORDIC giving cos and sin of the negated half angle.
module euq_cordic import euq_pkg::*; #(
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [ANGLE_BITS-1:0] angle_i,
  output logic signed [CW-1:0]         cos_o,
  output logic signed [CW-1:0]         sin_o
);

  logic signed [CW-1:0] x_q [CORDIC_STEPS];
  logic signed [CW-1:0] y_q [CORDIC_STEPS];
  logic signed [CW-1:0] z_q [CORDIC_STEPS];
  logic signed [CW-1:0] z_init;

  // Negated half angle in units where pi = 2^32.
  assign z_init = -($signed({{(CW-ANGLE_BITS){angle_i[ANGLE_BITS-1]}}, angle_i})
                    <<< (32-ANGLE_BITS));

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CW-1:0] x_in, y_in, z_in, x_d, y_d, z_d, dx, dy, t;
    if (i == 0) begin : g_first
      assign x_in = GAIN_Q30;
      assign y_in = '0;
      assign z_in = z_init;
    end else begin : g_rest
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end
    always_comb begin
      dx = y_in >>> (i % 32);
      dy = x_in >>> (i % 32);
      t  = atan_step(5'(i % 32));
      if (!z_in[CW-1]) begin
        x_d = x_in - dx;
        y_d = y_in + dy;
        z_d = z_in - t;
      end else begin
        x_d = x_in + dx;
        y_d = y_in - dy;
        z_d = z_in + t;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i] <= x_d;
        y_q[i] <= y_d;
        z_q[i] <= z_d;
      end
    end
  end

  assign cos_o = x_q[CORDIC_STEPS-1];
  assign sin_o = y_q[CORDIC_STEPS-1];

endmodule

// ===== rtl/euq_checker.sv =====
// Port-level checker for the Euler-to-quaternion block, bound to the top level.
`include "euler_angles_to_quaternion_assert.svh"

module euq_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  logic [7:0] cnt_q;

  // Beats taken in but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 8'(in_valid_i && in_ready_i) - 8'(out_valid_i && out_ready_i);
    end
  end

  `EUQ_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `EUQ_ASSERT_NOW(a_ready_follows, out_ready_i, in_ready_i)
  `EUQ_ASSERT_NOW(a_stall_has_result, !in_ready_i, out_valid_i)
  `EUQ_ASSERT_NOW(a_no_invented, out_valid_i, cnt_q != 8'd0)

endmodule

bind euler_angles_to_quaternion euq_checker u_euq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);

// ===== verif/euq_tb_if.sv =====
// Package of testbench types for angle triples and quaternions.
package euq_tb_pkg;
  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } angles_t;
  typedef struct {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;
endpackage

// ===== verif/tb.sv =====
// Testbench for the Euler-angles-to-quaternion block: directed and random angle triples,
// each checked against a fixed-point CORDIC quaternion predictor.
module tb;
  import euq_pkg::*;
  import euq_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  euq_in_if #(.ANGLE_BITS(16)) in_ch ();
  euq_out_if #(.OUT_BITS(16)) out_ch ();

  euler_angles_to_quaternion dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  quat_t expected_quats[$];
  int    n_errors = 0;
  bit    hold_output = 1'b0;
  bit    no_output_stalls = 1'b0;

  // Pipeline depth of the block, taken from the package defaults.
  localparam int LATENCY = CORDIC_STEPS_DEF + 5;

  // Arithmetic right shift on 64 bits; SystemVerilog >>> on a signed value floors.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // Rotation-mode CORDIC: cosine and sine of the negated half angle, both Q2.30.
  function automatic void half_angle_trig(input logic signed [15:0] a,
                                          output longint c, output longint s);
    longint z;
    longint xv;
    longint yv;
    longint dx;
    longint dy;
    longint step;
    z  = -(longint'(a) * (64'sd1 <<< 16));
    xv = 64'sd652032874;
    yv = 64'sd0;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx   = floor_shift(yv, i);
      dy   = floor_shift(xv, i);
      step = longint'(ATAN_TAB[i]);
      if (z >= 0) begin
        xv -= dx;
        yv += dy;
        z  -= step;
      end else begin
        xv += dx;
        yv -= dy;
        z  += step;
      end
    end
    c = xv;
    s = yv;
  endfunction

  function automatic longint triple_product(longint a, longint b, longint c);
    return floor_shift(floor_shift(a * b, 30) * c, 30);
  endfunction

  // Round a Q2.30 sum to Q1.15 by half an LSB, then saturate.
  function automatic logic signed [15:0] round_to_q15(longint v);
    longint r;
    r = floor_shift(v + (64'sd1 <<< 14), 15);
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < -64'sd32768) r = -64'sd32768;
    return r[15:0];
  endfunction

  function automatic quat_t quaternion_of(angles_t a);
    longint cx, sx, cy, sy, cz, sz;
    quat_t q;
    half_angle_trig(a.ax, cx, sx);
    half_angle_trig(a.ay, cy, sy);
    half_angle_trig(a.az, cz, sz);
    q.w = round_to_q15(triple_product(cz, cx, cy) + triple_product(sz, sx, sy));
    q.x = round_to_q15(triple_product(cz, sx, cy) - triple_product(sz, cx, sy));
    q.y = round_to_q15(triple_product(cz, cx, sy) + triple_product(sz, sx, cy));
    q.z = round_to_q15(triple_product(sz, cx, cy) - triple_product(cz, sx, sy));
    return q;
  endfunction

  // Offer one triple, after a random gap unless no_gap is set, and wait until the block takes the beat.
  // Valid stays high after acceptance so that a following beat can go straight
  // on; a gap or a drain takes it low again in the same step.
  // The expectation is queued at acceptance so the checker always sees it first.
  task automatic send_angles(angles_t a, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.angle_x <= a.ax;
    in_ch.angle_y <= a.ay;
    in_ch.angle_z <= a.az;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_quats.push_back(quaternion_of(a));
  endtask

  function automatic angles_t random_angles();
    angles_t a;
    a.ax = 16'($urandom);
    a.ay = 16'($urandom);
    a.az = 16'($urandom);
    return a;
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (expected_quats.size() != 0);
  endtask

  // Receiver: a fresh stall length per beat; ready is held low while a long hold-off
  // runs, and held high for stretches with no stalls.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_output_stalls ? 0 : $urandom_range(0, 12);
      if (stall != 0 || hold_output) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        while (hold_output) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // Every accepted quaternion beat is checked against the oldest expectation.
  always @(posedge clk_i) begin
    quat_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_quats.size() == 0) begin
        $error("quaternion beat with no expectation: w=%0d x=%0d y=%0d z=%0d",
               out_ch.quat_w, out_ch.quat_x, out_ch.quat_y, out_ch.quat_z);
        n_errors++;
      end else begin
        e = expected_quats.pop_front();
        if (out_ch.quat_w !== e.w) begin
          $error("quat_w: expected %0d, got %0d", e.w, out_ch.quat_w);
          n_errors++;
        end
        if (out_ch.quat_x !== e.x) begin
          $error("quat_x: expected %0d, got %0d", e.x, out_ch.quat_x);
          n_errors++;
        end
        if (out_ch.quat_y !== e.y) begin
          $error("quat_y: expected %0d, got %0d", e.y, out_ch.quat_y);
          n_errors++;
        end
        if (out_ch.quat_z !== e.z) begin
          $error("quat_z: expected %0d, got %0d", e.z, out_ch.quat_z);
          n_errors++;
        end
      end
    end
  end

  // Extremes of each angle, the minus-pi case where the half angle is exactly a
  // quarter turn, the zero rotation which saturates w at +1.0, and single bits.
  task automatic test_directed();
    logic signed [15:0] edges[6] = '{16'sh8000, 16'sh7fff, 16'sh0000,
                                     16'sh0001, 16'shffff, 16'sh4000};
    angles_t a;
    for (int i = 0; i < 6; i++) begin
      a.ax = edges[i]; a.ay = '0; a.az = '0; send_angles(a);
      a.ax = '0; a.ay = edges[i]; send_angles(a);
      a.ay = '0; a.az = edges[i]; send_angles(a);
    end
    a.ax = 16'sh8000; a.ay = 16'sh8000; a.az = 16'sh8000; send_angles(a);
    a.ax = 16'sh7fff; a.ay = 16'sh7fff; a.az = 16'sh7fff; send_angles(a);
    a.ax = 16'shc000; a.ay = 16'sh4000; a.az = 16'shc000; send_angles(a);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_angles(random_angles());
  endtask

  // Back-to-back beats with neither side stalling, so the pipeline runs at full rate.
  task automatic test_full_rate(int count);
    no_output_stalls = 1'b1;
    for (int i = 0; i < count; i++) send_angles(random_angles(), 1'b1);
    wait_drained();
    no_output_stalls = 1'b0;
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // beats; the pipeline fills and the input must stall without losing anything.
  task automatic test_backpressure();
    fork
      begin
        hold_output = 1'b1;
        repeat (4 * LATENCY) @(posedge clk_i);
        hold_output = 1'b0;
      end
      for (int i = 0; i < 2 * LATENCY; i++) send_angles(random_angles(), 1'b1);
    join
    // The sender then waits for every expected quaternion before going on.
    wait_drained();
  endtask

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.angle_x <= '0;
    in_ch.angle_y <= '0;
    in_ch.angle_z <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(700);
    test_backpressure();
    test_full_rate(300);
    test_random(500);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("PASS euler_angles_to_quaternion");
    end else begin
      $display("FAIL euler_angles_to_quaternion");
    end
    $finish;
  end

  // Watchdog for a run of roughly 1600 beats: reports a failure if it does not finish in time.
  initial begin
    #1000000;
    $display("FAIL euler_angles_to_quaternion");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/euq_pkg.sv
rtl/euq_if.sv
rtl/euq_cordic.sv
rtl/euler_angles_to_quaternion.sv
rtl/euq_checker.sv
verif/euq_tb_if.sv
verif/tb.sv
